// ===== sv/lobm_pkg.sv =====
// Shared constants, types and helpers for the order book matcher.
package lobm_pkg;

    localparam int unsigned DEF_BOOK_DEPTH = 64;
    localparam int unsigned PW = 30;
    localparam int unsigned AW = 30;
    localparam logic [PW-1:0] BACKLOG_MOD = 30'd1000000007;

    localparam logic OP_BUY  = 1'b0;
    localparam logic OP_SELL = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MATCH,
        ST_REST
    } t_state;

    // Broadcast command from the controller to every cell of one book.
    typedef struct packed {
        logic          pop;     // shift every entry one place towards the head
        logic          dec;     // reduce the head amount by take
        logic [AW-1:0] take;
        logic          ins;     // insert a new entry in sorted order
        logic [PW-1:0] price;
        logic [AW-1:0] amount;
    } t_cell_cmd;

    // Modular add of two values both below the modulus.
    function automatic logic [PW-1:0] mod_add(input logic [PW-1:0] a, input logic [PW-1:0] b);
        logic [PW:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, BACKLOG_MOD}) begin
            s = s - {1'b0, BACKLOG_MOD};
        end
        return s[PW-1:0];
    endfunction

    // Reduce a 30-bit value below the modulus; one subtract suffices.
    function automatic logic [PW-1:0] mod_red(input logic [AW-1:0] a);
        logic [PW-1:0] r;
        r = (a >= BACKLOG_MOD) ? a - BACKLOG_MOD : a;
        return r;
    endfunction

endpackage

// ===== sv/lobm_cell.sv =====
// One book slot: holds a price and amount, shifts towards head or tail.
module lobm_cell
    import lobm_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_is_buy_book,
    input  logic          i_is_head,
    input  t_cell_cmd     i_cmd,
    input  logic          i_occ,        // this slot is below the count
    input  logic          i_prev_occ,   // the slot towards the head is occupied
    input  logic [PW-1:0] i_prev_price,
    input  logic [AW-1:0] i_prev_amount,
    input  logic          i_prev_after, // new entry goes after the head-side slot
    input  logic [PW-1:0] i_next_price,
    input  logic [AW-1:0] i_next_amount,
    output logic [PW-1:0] o_price,
    output logic [AW-1:0] o_amount,
    output logic          o_after       // new entry goes after this slot
);

    logic [PW-1:0] r_price, n_price;
    logic [AW-1:0] r_amount, n_amount;

    assign o_price  = r_price;
    assign o_amount = r_amount;

    // Entry keeps priority over a new one of equal or worse price.
    assign o_after = i_occ &&
        (i_is_buy_book ? (r_price >= i_cmd.price) : (r_price <= i_cmd.price));

    always_comb begin
        n_price  = r_price;
        n_amount = r_amount;
        if (i_cmd.pop) begin
            n_price  = i_next_price;
            n_amount = i_next_amount;
        end else if (i_cmd.dec && i_is_head) begin
            n_amount = r_amount - i_cmd.take;
        end else if (i_cmd.ins) begin
            if (i_is_head ? !o_after : (i_prev_after && !o_after)) begin
                n_price  = i_cmd.price;
                n_amount = i_cmd.amount;
            end else if (!i_is_head && !i_prev_after && i_prev_occ) begin
                n_price  = i_prev_price;
                n_amount = i_prev_amount;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_price  <= n_price;
        r_amount <= n_amount;
    end

endmodule

// ===== sv/lobm_book.sv =====
// One side of the book: a chain of slots with its entry count.
module lobm_book
    import lobm_pkg::*;
#(
    parameter int unsigned BOOK_DEPTH = DEF_BOOK_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_is_buy_book,
    input  t_cell_cmd     i_cmd,
    output logic [PW-1:0] o_head_price,
    output logic [AW-1:0] o_head_amount,
    output logic          o_empty,
    output logic          o_full
);

    localparam int unsigned CW = $clog2(BOOK_DEPTH + 1);

    logic [CW-1:0] r_count, n_count;
    logic [PW-1:0] w_price  [BOOK_DEPTH];
    logic [AW-1:0] w_amount [BOOK_DEPTH];
    logic          w_after  [BOOK_DEPTH];
    logic          w_occ    [BOOK_DEPTH];

    assign o_head_price  = w_price[0];
    assign o_head_amount = w_amount[0];
    assign o_empty       = (r_count == '0);
    assign o_full        = (r_count == CW'(BOOK_DEPTH));

    genvar g;
    generate
        for (g = 0; g < BOOK_DEPTH; g++) begin : g_cell
            assign w_occ[g] = (CW'(g) < r_count);
            lobm_cell u_cell (
                .i_clk         (i_clk),
                .i_is_buy_book (i_is_buy_book),
                .i_is_head     (g == 0),
                .i_cmd         (i_cmd),
                .i_occ         (w_occ[g]),
                .i_prev_occ    ((g == 0) ? 1'b0 : w_occ[(g == 0) ? 0 : g-1]),
                .i_prev_price  (w_price[(g == 0) ? 0 : g-1]),
                .i_prev_amount (w_amount[(g == 0) ? 0 : g-1]),
                .i_prev_after  ((g == 0) ? 1'b1 : w_after[(g == 0) ? 0 : g-1]),
                .i_next_price  (w_price[(g == BOOK_DEPTH-1) ? g : g+1]),
                .i_next_amount (w_amount[(g == BOOK_DEPTH-1) ? g : g+1]),
                .o_price       (w_price[g]),
                .o_amount      (w_amount[g]),
                .o_after       (w_after[g])
            );
        end
    endgenerate

    always_comb begin
        n_count = r_count;
        if (i_cmd.pop) begin
            n_count = r_count - CW'(1);
        end else if (i_cmd.ins && !o_full) begin
            n_count = r_count + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

endmodule

// ===== sv/limit_order_book_matcher.sv =====
// Top level: order book matcher with two chained-slot books and a controller.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-------------------------------------------
//  order   | in        | i_valid / o_stall   | i_op, i_order_price, i_order_amount
//  result  | out       | o_valid / i_stall   | o_filled_amount, o_rested_amount,
//          |           |                     | o_backlog_total, o_book_overflow
//
// An order is latched in the idle state; the match state then walks the opposite
// book's head slot once per cycle until it finds that matching has stopped, and
// the rest state rests or drops the remainder and publishes the result.
// Reset (synchronous, active low) empties both books and zeroes the backlog;
// slot contents are left as they are, as only slots below the count are read.
// One order is in flight at a time; the next order is taken once the result is
// published, and it holds in the rest cycle while the previous result is stalled.
module limit_order_book_matcher
    import lobm_pkg::*;
#(
    parameter int unsigned BOOK_DEPTH = DEF_BOOK_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  logic          i_op,
    input  logic [PW-1:0] i_order_price,
    input  logic [AW-1:0] i_order_amount,
    output logic          o_valid,
    input  logic          i_stall,
    output logic [AW-1:0] o_filled_amount,
    output logic [AW-1:0] o_rested_amount,
    output logic [PW-1:0] o_backlog_total,
    output logic          o_book_overflow
);

    t_state r_state, n_state;

    // Order under work.
    logic          r_op;
    logic [PW-1:0] r_price;
    logic [AW-1:0] r_rem, n_rem;
    logic [AW-1:0] r_filled, n_filled;
    logic [PW-1:0] r_backlog, n_backlog;

    // Result register.
    logic          r_valid, n_valid;
    logic [AW-1:0] r_out_filled, n_out_filled;
    logic [AW-1:0] r_out_rested, n_out_rested;
    logic [PW-1:0] r_out_backlog, n_out_backlog;
    logic          r_out_ovf, n_out_ovf;

    t_cell_cmd     buy_cmd, sell_cmd;
    logic [PW-1:0] buy_hp, sell_hp;
    logic [AW-1:0] buy_ha, sell_ha;
    logic          buy_empty, sell_empty, buy_full, sell_full;

    // Opposite book's head as seen by the current order.
    logic [PW-1:0] opp_hp;
    logic [AW-1:0] opp_ha, take;
    logic          opp_empty, crosses, own_full, accept;

    lobm_book #(.BOOK_DEPTH(BOOK_DEPTH)) u_buy (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_is_buy_book (1'b1),
        .i_cmd         (buy_cmd),
        .o_head_price  (buy_hp),
        .o_head_amount (buy_ha),
        .o_empty       (buy_empty),
        .o_full        (buy_full)
    );

    lobm_book #(.BOOK_DEPTH(BOOK_DEPTH)) u_sell (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_is_buy_book (1'b0),
        .i_cmd         (sell_cmd),
        .o_head_price  (sell_hp),
        .o_head_amount (sell_ha),
        .o_empty       (sell_empty),
        .o_full        (sell_full)
    );

    assign o_stall = (r_state != ST_IDLE);
    assign accept  = i_valid && !o_stall;

    assign opp_hp    = (r_op == OP_BUY) ? sell_hp : buy_hp;
    assign opp_ha    = (r_op == OP_BUY) ? sell_ha : buy_ha;
    assign opp_empty = (r_op == OP_BUY) ? sell_empty : buy_empty;
    assign own_full  = (r_op == OP_BUY) ? buy_full : sell_full;
    assign crosses   = (r_op == OP_BUY) ? (opp_hp <= r_price) : (opp_hp >= r_price);
    assign take      = (opp_ha < r_rem) ? opp_ha : r_rem;

    assign o_valid         = r_valid;
    assign o_filled_amount = r_out_filled;
    assign o_rested_amount = r_out_rested;
    assign o_backlog_total = r_out_backlog;
    assign o_book_overflow = r_out_ovf;

    always_comb begin
        n_state       = r_state;
        n_rem         = r_rem;
        n_filled      = r_filled;
        n_backlog     = r_backlog;
        n_valid       = r_valid;
        n_out_filled  = r_out_filled;
        n_out_rested  = r_out_rested;
        n_out_backlog = r_out_backlog;
        n_out_ovf     = r_out_ovf;
        buy_cmd      = '0;
        sell_cmd     = '0;
        buy_cmd.price  = r_price;
        sell_cmd.price = r_price;
        buy_cmd.take   = take;
        sell_cmd.take  = take;
        buy_cmd.amount  = r_rem;
        sell_cmd.amount = r_rem;

        // Drop the result once taken.
        if (r_valid && !i_stall) begin
            n_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_rem    = i_order_amount;
                    n_filled = '0;
                    n_state  = ST_MATCH;
                end
            end
            ST_MATCH: begin
                // Consume one head per cycle while it crosses.
                if (r_rem != '0 && !opp_empty && crosses) begin
                    n_rem    = r_rem - take;
                    n_filled = r_filled + take;
                    n_backlog = mod_add(r_backlog, BACKLOG_MOD - mod_red(take));
                    if (r_op == OP_BUY) begin
                        sell_cmd.pop = (take == opp_ha);
                        sell_cmd.dec = (take != opp_ha);
                    end else begin
                        buy_cmd.pop = (take == opp_ha);
                        buy_cmd.dec = (take != opp_ha);
                    end
                end else begin
                    n_state = ST_REST;
                end
            end
            ST_REST: begin
                // Hold until the previous result has left the register.
                if (!r_valid || !i_stall) begin
                    n_out_filled = r_filled;
                    n_out_rested = '0;
                    n_out_ovf    = 1'b0;
                    if (r_rem != '0) begin
                        if (own_full) begin
                            n_out_ovf = 1'b1;
                        end else begin
                            n_out_rested = r_rem;
                            n_backlog    = mod_add(r_backlog, mod_red(r_rem));
                            if (r_op == OP_BUY) begin
                                buy_cmd.ins = 1'b1;
                            end else begin
                                sell_cmd.ins = 1'b1;
                            end
                        end
                    end
                    n_out_backlog = n_backlog;
                    n_valid       = 1'b1;
                    n_state       = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_valid   <= 1'b0;
            r_backlog <= '0;
        end else begin
            r_state   <= n_state;
            r_valid   <= n_valid;
            r_backlog <= n_backlog;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op    <= i_op;
            r_price <= i_order_price;
        end
        r_rem         <= n_rem;
        r_filled      <= n_filled;
        r_out_filled  <= n_out_filled;
        r_out_rested  <= n_out_rested;
        r_out_backlog <= n_out_backlog;
        r_out_ovf     <= n_out_ovf;
    end

endmodule

// ===== verif/tb_top.sv =====
// Testbench for the order book matcher: directed and random orders against a behavioural book.
module tb_top;
    import lobm_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = DEF_BOOK_DEPTH;
    localparam longint unsigned MODV = 64'd1000000007;

    logic          i_clk;
    logic          i_rst_n;
    logic          i_valid;
    logic          o_stall;
    logic          i_op;
    logic [PW-1:0] i_order_price;
    logic [AW-1:0] i_order_amount;
    logic          o_valid;
    logic          i_stall;
    logic [AW-1:0] o_filled_amount;
    logic [AW-1:0] o_rested_amount;
    logic [PW-1:0] o_backlog_total;
    logic          o_book_overflow;

    limit_order_book_matcher u_dut (.*);

    typedef struct packed {
        logic [AW-1:0] filled;
        logic [AW-1:0] rested;
        logic [PW-1:0] backlog;
        logic          overflow;
    } t_fill;

    // Behavioural books, best first, equal prices in arrival order
    logic [PW-1:0] bid_px[$];
    logic [AW-1:0] bid_qty[$];
    logic [PW-1:0] ask_px[$];
    logic [AW-1:0] ask_qty[$];
    logic [PW-1:0] backlog_acc;

    t_fill pending_fills[$];
    int    mismatches;
    bit    hold_off_req;   // ask the receiver process for a long stall
    bit    burst_mode;     // enables sender gaps and random receiver stalls

    always begin
        i_clk = 1'b1; #6;
        i_clk = 1'b0; #6;
    end

    // Work out one order's fill against the books and update them.
    function automatic t_fill predict_fill(logic op, logic [PW-1:0] px, logic [AW-1:0] qty);
        t_fill f;
        logic [AW-1:0] left;
        logic [AW-1:0] take;
        longint unsigned b;
        int pos;
        left = qty;
        f = '0;
        if (op == OP_BUY) begin
            while (left != 0 && ask_px.size() != 0 && ask_px[0] <= px) begin
                take = (ask_qty[0] < left) ? ask_qty[0] : left;
                left -= take; f.filled += take; ask_qty[0] -= take;
                if (ask_qty[0] == 0) begin
                    void'(ask_px.pop_front()); void'(ask_qty.pop_front());
                end
            end
        end else begin
            while (left != 0 && bid_px.size() != 0 && bid_px[0] >= px) begin
                take = (bid_qty[0] < left) ? bid_qty[0] : left;
                left -= take; f.filled += take; bid_qty[0] -= take;
                if (bid_qty[0] == 0) begin
                    void'(bid_px.pop_front()); void'(bid_qty.pop_front());
                end
            end
        end
        if (left != 0) begin
            if (op == OP_BUY) begin
                if (bid_px.size() >= DEPTH) f.overflow = 1'b1;
                else begin
                    pos = 0;
                    while (pos < bid_px.size() && bid_px[pos] >= px) pos++;
                    bid_px.insert(pos, px); bid_qty.insert(pos, left);
                    f.rested = left;
                end
            end else begin
                if (ask_px.size() >= DEPTH) f.overflow = 1'b1;
                else begin
                    pos = 0;
                    while (pos < ask_px.size() && ask_px[pos] <= px) pos++;
                    ask_px.insert(pos, px); ask_qty.insert(pos, left);
                    f.rested = left;
                end
            end
        end
        b = longint'(backlog_acc) + MODV - (longint'(f.filled) % MODV);
        b = (b + longint'(f.rested)) % MODV;
        backlog_acc = b[PW-1:0];
        f.backlog = backlog_acc;
        return f;
    endfunction

    // Offer one order, hold it until accepted, then predict its fill.
    // Valid stays up into the next call, which either drops it for a gap
    // or offers the next order at once.
    task automatic send_order(logic op, logic [PW-1:0] px, logic [AW-1:0] qty);
        int gap;
        if (burst_mode && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 6);
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1; i_op <= op; i_order_price <= px; i_order_amount <= qty;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        pending_fills.push_back(predict_fill(op, px, qty));
        @(negedge i_clk);
    endtask

    // Receiver stall pattern, with an occasional long hold-off
    initial begin
        int n;
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_req) begin
                i_stall <= 1'b1;
                for (n = 0; n < 400; n++) @(negedge i_clk);
                hold_off_req = 1'b0;
                i_stall <= 1'b0;
            end else if (burst_mode) i_stall <= ($urandom_range(0, 3) == 0);
            else i_stall <= 1'b0;
        end
    end

    // Result checker
    always @(posedge i_clk) begin
        t_fill exp_f;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_fills.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result at %0t", $realtime);
            end else begin
                exp_f = pending_fills.pop_front();
                if (o_filled_amount !== exp_f.filled || o_rested_amount !== exp_f.rested ||
                    o_backlog_total !== exp_f.backlog ||
                    o_book_overflow !== exp_f.overflow) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp f=%0d r=%0d b=%0d o=%0d got f=%0d r=%0d b=%0d o=%0d",
                                 exp_f.filled, exp_f.rested, exp_f.backlog, exp_f.overflow,
                                 o_filled_amount, o_rested_amount, o_backlog_total,
                                 o_book_overflow);
                end
            end
        end
    end

    task automatic test_edges();
        send_order(OP_BUY, 30'd100, 30'd0);              // zero amount
        send_order(OP_BUY, 30'd100, 30'd10);
        send_order(OP_BUY, 30'd100, 30'd20);             // equal price, queues behind
        send_order(OP_BUY, 30'd0, 30'h3FFFFFFF);
        send_order(OP_SELL, 30'd100, 30'd15);            // partial of two equal bids
        send_order(OP_SELL, 30'h3FFFFFFF, 30'h3FFFFFFF);
        send_order(OP_BUY, 30'h3FFFFFFF, 30'h3FFFFFFF);  // sweeps the ask
        send_order(OP_SELL, 30'd0, 30'h3FFFFFFF);        // fills against both bids, leaving part of the last one
        send_order(OP_SELL, 30'd50, 30'd0);
        send_order(OP_BUY, 30'd0, 30'd1);
    endtask

    // Fill both books to depth and beyond, then sweep each of them
    task automatic test_full_book();
        int k;
        for (k = 0; k < DEPTH + 4; k++) send_order(OP_BUY, PW'(1 + (k % 5)), 30'd7);
        for (k = 0; k < DEPTH + 4; k++) send_order(OP_SELL, PW'(1000 + k), 30'd3);
        send_order(OP_SELL, 30'd0, 30'h3FFFFFFF);
        send_order(OP_BUY, 30'h3FFFFFFF, 30'h3FFFFFFF);
    endtask

    // Long receiver hold-off while orders keep coming
    task automatic test_hold_off();
        int k;
        hold_off_req = 1'b1;
        for (k = 0; k < 30; k++) send_order(logic'(k & 1), PW'(500 + $urandom_range(0, 20)),
                                            AW'($urandom_range(1, 50)));
    endtask

    task automatic test_random(int count);
        int k;
        logic [PW-1:0] px;
        logic [AW-1:0] qty;
        for (k = 0; k < count; k++) begin
            case ($urandom_range(0, 9))
                0: begin px = PW'($urandom()); qty = AW'($urandom()); end
                1: begin px = PW'($urandom_range(0, 40)); qty = '0; end
                default: begin
                    px = PW'(1000 + $urandom_range(0, 40));
                    qty = ($urandom_range(0, 15) == 0) ? AW'($urandom())
                                                       : AW'($urandom_range(1, 200));
                end
            endcase
            send_order(1'($urandom_range(0, 1)), px, qty);
        end
    endtask

    initial begin
        int wait_cycles;
        i_rst_n = 1'b0; i_valid = 1'b0; i_op = OP_BUY;
        i_order_price = '0; i_order_amount = '0;
        backlog_acc = '0; mismatches = 0;
        hold_off_req = 0; burst_mode = 0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_edges();
        burst_mode = 1;
        test_full_book();
        test_hold_off();
        test_random(1570);
        i_valid <= 1'b0;
        wait_cycles = 0;
        while (pending_fills.size() != 0 && wait_cycles < 100000) begin
            @(posedge i_clk); wait_cycles++;
        end
        repeat (200) @(posedge i_clk);
        if (mismatches == 0 && pending_fills.size() == 0)
            $display("** limit_order_book_matcher: PASSED **");
        else
            $display("** limit_order_book_matcher: FAILED **");
        $finish;
    end

    initial begin
        #20ms;
        $display("** limit_order_book_matcher: FAILED **");
        $finish;
    end
endmodule

// ===== files.f =====
sv/lobm_pkg.sv
sv/lobm_cell.sv
sv/lobm_book.sv
sv/limit_order_book_matcher.sv
verif/tb_top.sv
